@@ hdl/ali_pkg.sv @@
// Shared constants, codes and types of the array list block.
// Depends on nothing; every other file of the block but ali_ram imports it.
`timescale 1ns / 1ps

package ali_pkg;

  // Storage geometry.
  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Field widths of the request and result transfers.
  localparam int OP_W  = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd3;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] found_position;
    logic [LEN_W-1:0] list_length;
  } res_t;

endpackage

@@ hdl/ali_if.sv @@
// Valid/ready channel interfaces for requests and results of the array list.
// Depends on ali_pkg for the field widths.
`timescale 1ns / 1ps

interface ali_req_if
  import ali_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] element_value;

  modport source (output valid, output operation, output position,
                  output element_value, input ready);
  modport sink   (input valid, input operation, input position,
                  input element_value, output ready);
endinterface

interface ali_rsp_if
  import ali_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [VAL_W-1:0] read_value;
  logic [LEN_W-1:0] found_position;
  logic [LEN_W-1:0] list_length;

  modport source (output valid, output status, output read_value,
                  output found_position, output list_length, input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input list_length, output ready);
endinterface

@@ hdl/ali_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module ali_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/ali_engine.sv @@
// Sequencer of the array list: checks a request, walks the element memory
// and keeps the length. Depends on ali_pkg and ali_ram.
`timescale 1ns / 1ps

module ali_engine
  import ali_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_READ,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [ADDR_W-1:0]     pos_m1_q, pos_m1_d;
  logic [ELEM_WIDTH-1:0] val_q, val_d;
  logic [ADDR_W-1:0]     cur_q, cur_d;
  logic [ADDR_W-1:0]     stop_q, stop_d;
  logic                  run_q, run_d;
  logic                  rv_q, rv_d;
  logic [ADDR_W-1:0]     ra_q, ra_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ST_W-1:0]       status_q, status_d;
  logic [ELEM_WIDTH-1:0] readv_q, readv_d;
  logic [CNT_W-1:0]      found_q, found_d;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             is_empty, is_full, ins_bad, rd_bad;

  assign pos_ext  = CMP_W'(req_i.position);
  assign cnt_ext  = CMP_W'(count_q);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign ins_bad  = (req_i.position == '0) || (pos_ext > cnt_ext + 1'b1);
  assign rd_bad   = (req_i.position == '0) || (pos_ext > cnt_ext);

  ali_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_m1_d  = pos_m1_q;
    val_d     = val_q;
    cur_d     = cur_q;
    stop_d    = stop_q;
    run_d     = run_q;
    rv_d      = 1'b0;
    ra_d      = ra_q;
    count_d   = count_q;
    status_d  = status_q;
    readv_d   = readv_q;
    found_d   = found_q;
    ram_we    = 1'b0;
    ram_waddr = ra_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cur_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    // The walking states issue one read per cycle while entries remain.
    if ((state_q == S_UP || state_q == S_READ || state_q == S_SCAN) && run_q) begin
      ram_re = 1'b1;
      rv_d   = 1'b1;
      ra_d   = cur_q;
      run_d  = (cur_q != stop_q);
      cur_d  = (state_q == S_READ) ? ADDR_W'(cur_q + 1'b1) : ADDR_W'(cur_q - 1'b1);
    end

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d     = req_i.operation;
          pos_m1_d = ADDR_W'(pos_ext - 1'b1);
          val_d    = ELEM_WIDTH'(req_i.element_value);
          readv_d  = '0;
          found_d  = '0;
          status_d = ST_OK;
          run_d    = 1'b1;
          state_d  = S_DONE;
          unique case (req_i.operation)
            OP_INSERT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else if (ins_bad) begin
                status_d = ST_BADPOS;
              end else if (pos_ext <= cnt_ext) begin
                cur_d   = ADDR_W'(cnt_ext - 1'b1);
                stop_d  = ADDR_W'(pos_ext - 1'b1);
                state_d = S_UP;
              end else begin
                state_d = S_PUT;
              end
            end
            OP_DELETE, OP_GET: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else if (rd_bad) begin
                status_d = ST_BADPOS;
              end else begin
                cur_d   = ADDR_W'(pos_ext - 1'b1);
                stop_d  = (req_i.operation == OP_DELETE) ? ADDR_W'(cnt_ext - 1'b1)
                                                         : ADDR_W'(pos_ext - 1'b1);
                state_d = S_READ;
              end
            end
            OP_LOCATE: begin
              if (!is_empty) begin
                cur_d   = ADDR_W'(cnt_ext - 1'b1);
                stop_d  = '0;
                state_d = S_SCAN;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_UP: begin
        // Entry read last cycle moves one place up.
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(ra_q + 1'b1);
        end
        if (!run_q) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1_q;
        ram_wdata = val_q;
        count_d   = CNT_W'(count_q + 1'b1);
        state_d   = S_DONE;
      end
      S_READ: begin
        // The first entry read is the result; later ones move one place down.
        if (rv_q) begin
          if (ra_q == pos_m1_q) begin
            readv_d = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(ra_q - 1'b1);
          end
        end
        if (!run_q) begin
          if (op_q == OP_DELETE) begin
            count_d = CNT_W'(count_q - 1'b1);
          end
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (rv_q && (ram_rdata == val_q)) begin
          found_d = CNT_W'(CNT_W'(ra_q) + 1'b1);
          state_d = S_DONE;
        end else if (!run_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_INSERT;
      pos_m1_q <= '0;
      val_q    <= '0;
      cur_q    <= '0;
      stop_q   <= '0;
      run_q    <= 1'b0;
      rv_q     <= 1'b0;
      ra_q     <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
      readv_q  <= '0;
      found_q  <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      pos_m1_q <= pos_m1_d;
      val_q    <= val_d;
      cur_q    <= cur_d;
      stop_q   <= stop_d;
      run_q    <= run_d;
      rv_q     <= rv_d;
      ra_q     <= ra_d;
      count_q  <= count_d;
      status_q <= status_d;
      readv_q  <= readv_d;
      found_q  <= found_d;
    end
  end

  assign res_o.status         = status_q;
  assign res_o.read_value     = VAL_W'(readv_q);
  assign res_o.found_position = LEN_W'(found_q);
  assign res_o.list_length    = LEN_W'(count_q);

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write hit the same entry in one cycle");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == CNT_W'($past(count_q) + 1'b1)) ||
       ($past(count_q) == CNT_W'(count_q + 1'b1))))
    else $error("list length moved by more than one");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (status_q == ST_FULL)) |-> is_full)
    else $error("full status reported on a list that is not full");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> !ram_we)
    else $error("memory written while taking a request");
`endif

endmodule

@@ hdl/array_list_insert_delete.sv @@
// Top level of the array list: request channel, sequencer, result register.
// Depends on ali_pkg, ali_if and ali_engine.
//
//   channel | modport | direction | payload
//   --------+---------+-----------+-------------------------------------------------
//   req_i   | sink    | in        | operation, position, element_value
//   rsp_o   | source  | out       | status, read_value, found_position, list_length
//
// One request is in work at a time; n is the list length, p the position.
// Errors go straight to the result; get reads entry p; delete reads p to n;
// insert moves entries n down to p one place up (an append at the tail does
// not), then writes; locate scans from n down and stops at the first match.
// Each walk steps the element memory one entry per cycle on its single read
// port, with each moved entry written back on the write port.
// Reset clears the length and the control state; the element memory is not
// cleared, so the block takes requests right after reset.
// A stalled result waits in the output register; the next request is taken
// while it waits, and the sequencer holds only when a second result is ready.
`timescale 1ns / 1ps

module array_list_insert_delete
  import ali_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ali_req_if.sink   req_i,
  ali_rsp_if.source rsp_o
);

  req_t req;
  res_t res;
  logic res_valid, res_ready;

  logic rsp_valid_q, rsp_valid_d;
  res_t rsp_q;

  // Gather the request fields into one bundle for the sequencer.
  assign req.operation     = req_i.operation;
  assign req.position      = req_i.position;
  assign req.element_value = req_i.element_value;

  ali_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The output register accepts a new result when empty or being emptied.
  assign res_ready = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (res_valid && res_ready) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload needs no reset; it is only looked at while valid is high.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_q.status;
  assign rsp_o.read_value     = rsp_q.read_value;
  assign rsp_o.found_position = rsp_q.found_position;
  assign rsp_o.list_length    = rsp_q.list_length;

endmodule
